@@ design/ehpd_pkg.sv @@
// shared types, codes and helpers for the eh pointer field decoder
// no dependencies; imported by every module of the block
package ehpd_pkg;

    localparam int MAX_LEB_BYTES  = 10;
    localparam int MAX_ALIGN_LOG2 = 6;
    localparam int CMD_DEPTH      = 4;
    localparam int CMD_PTR_W      = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH      = 2;

    localparam logic [7:0] ENC_OMIT    = 8'hFF;
    localparam logic [7:0] ENC_ALIGNED = 8'h50;

    localparam logic [3:0] TY_ULEB = 4'h1;
    localparam logic [3:0] TY_SLEB = 4'h9;
    localparam logic [3:0] TY_S2   = 4'hA;
    localparam logic [3:0] TY_S4   = 4'hB;

    localparam logic [2:0] MOD_PCREL   = 3'h1;
    localparam logic [2:0] MOD_TEXTREL = 3'h2;
    localparam logic [2:0] MOD_DATAREL = 3'h3;
    localparam logic [2:0] MOD_FUNCREL = 3'h4;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [1:0] CFG_TEXT_BASE  = 2'd0;
    localparam logic [1:0] CFG_DATA_BASE  = 2'd1;
    localparam logic [1:0] CFG_FUNC_BASE  = 2'd2;
    localparam logic [1:0] CFG_ALIGN_LOG2 = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PAD   = 3'd1,
        PH_FIXED = 3'd2,
        PH_ULEB  = 3'd3,
        PH_SLEB  = 3'd4
    } t_phase;

    typedef struct packed {
        logic        action;
        logic [7:0]  encoding;
        logic [63:0] pc_base;
        logic [5:0]  offset_low;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] pointer;
        logic [6:0]  byte_count;
        logic        written;
        logic        overlong;
    } t_result;

    typedef struct packed {
        logic [63:0] text_base;
        logic [63:0] data_base;
        logic [63:0] func_base;
        logic [2:0]  align_log2;
    } t_cfg;

    // classified transaction handed from front to back
    typedef struct packed {
        logic        is_start;
        logic        immediate;
        logic        imm_written;
        t_phase      init_phase;
        logic [7:0]  encoding;
        logic [63:0] pc;
        logic [5:0]  pad;
        logic [3:0]  size;
        logic [7:0]  data_byte;
    } t_cmd;

    function automatic logic [3:0] fixed_size(input logic [3:0] ty);
        logic [3:0] sz;
        unique case (ty)
            4'h2, 4'hA:             sz = 4'd2;
            4'h3, 4'hB:             sz = 4'd4;
            4'h0, 4'h4, 4'h8, 4'hC: sz = 4'd8;
            default:                sz = 4'd0;
        endcase
        return sz;
    endfunction

endpackage

@@ design/ehpd_front.sv @@
// front end: classifies incoming transactions and queues them for the back end
// depends on ehpd_pkg
module ehpd_front import ehpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_align_log2,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_item,
    output logic       o_cmd_valid,
    input  logic       i_cmd_pop,
    output t_cmd       o_cmd
);

    t_cmd                 r_q [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr, n_wr;
    logic [CMD_PTR_W-1:0] r_rd, n_rd;
    logic [CMD_PTR_W:0]   r_count, n_count;

    t_cmd       cls;
    logic       push_ok;
    logic       pop_ok;
    logic [2:0] lg;
    logic [5:0] mask;
    logic [5:0] pad;
    logic [7:0] enc;
    logic [3:0] ty;
    logic [3:0] sz;

    always_comb begin
        lg   = (i_align_log2 > 3'(MAX_ALIGN_LOG2)) ? 3'(MAX_ALIGN_LOG2) : i_align_log2;
        mask = 6'((7'd1 << lg) - 7'd1);
        enc  = i_item.encoding;
        pad  = 6'd0;
        if (enc == ENC_ALIGNED) begin
            pad = (6'd0 - i_item.offset_low) & mask;
            enc = 8'h00;
        end
        ty = enc[3:0];
        sz = fixed_size(ty);

        cls             = '0;
        cls.is_start    = (i_item.action == ACT_START);
        cls.encoding    = enc;
        cls.pc          = i_item.pc_base;
        cls.data_byte   = i_item.data_byte;
        cls.init_phase  = PH_IDLE;
        if (i_item.encoding == ENC_OMIT) begin
            cls.immediate   = 1'b1;
            cls.imm_written = 1'b0;
        end else if (ty == TY_ULEB) begin
            cls.init_phase = PH_ULEB;
        end else if (ty == TY_SLEB) begin
            cls.init_phase = PH_SLEB;
        end else if (sz != 4'd0) begin
            cls.size       = sz;
            cls.pad        = pad;
            cls.init_phase = (pad != 6'd0) ? PH_PAD : PH_FIXED;
        end else begin
            // unknown type answers at once
            cls.immediate   = 1'b1;
            cls.imm_written = 1'b1;
        end
    end

    assign full        = (r_count == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign push_ok     = push && !full;
    assign o_cmd_valid = (r_count != '0);
    assign pop_ok      = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_wr    = push_ok ? r_wr + 1'b1 : r_wr;
        n_rd    = pop_ok ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (CMD_PTR_W+1)'(push_ok) - (CMD_PTR_W+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (CMD_PTR_W+1)'(CMD_DEPTH))
        else $error("command queue overfilled");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && !push_ok && r_count == (CMD_PTR_W+1)'(1)) |=> !o_cmd_valid)
        else $error("command queue did not drain");

endmodule

@@ design/ehpd_back.sv @@
// back end: field sequencer, base addition and result queue
// depends on ehpd_pkg
module ehpd_back import ehpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_enc, n_enc;
    logic [63:0] r_pc, n_pc;
    logic [5:0]  r_pad, n_pad;
    logic [3:0]  r_left, n_left;
    logic [6:0]  r_taken, n_taken;
    logic [63:0] r_acc, n_acc;
    logic [6:0]  r_shift, n_shift;

    t_result     r_rq [RES_DEPTH];
    logic        r_rwr;
    logic        r_rrd;
    logic [1:0]  r_rcount;

    logic        go;
    logic        fin;
    logic        pad_done;
    logic        res_push;
    logic        res_pop;
    t_result     res;
    logic [6:0]  taken1;
    logic [6:0]  sh_new;
    logic [63:0] acc_new;
    logic [63:0] raw;
    logic [63:0] base;
    logic        limit;
    logic        ovl;

    assign go        = i_cmd_valid && (r_rcount < 2'(RES_DEPTH));
    assign o_cmd_pop = go;

    // datapath and result generation
    always_comb begin
        n_enc    = r_enc;
        n_pc     = r_pc;
        n_pad    = r_pad;
        n_left   = r_left;
        n_taken  = r_taken;
        n_acc    = r_acc;
        n_shift  = r_shift;
        taken1   = r_taken + 7'd1;
        sh_new   = r_shift;
        acc_new  = r_acc;
        raw      = '0;
        base     = '0;
        limit    = 1'b0;
        ovl      = 1'b0;
        fin      = 1'b0;
        pad_done = 1'b0;
        res_push = 1'b0;
        res      = '0;
        if (go) begin
            if (i_cmd.is_start) begin
                n_enc   = i_cmd.encoding;
                n_pc    = i_cmd.pc;
                n_taken = '0;
                n_left  = i_cmd.size;
                n_pad   = i_cmd.pad;
                n_acc   = '0;
                n_shift = '0;
                if (i_cmd.immediate) begin
                    res_push    = 1'b1;
                    res.written = i_cmd.imm_written;
                end
            end else if (r_phase != PH_IDLE) begin
                n_taken = taken1;
                unique case (r_phase)
                    PH_PAD: begin
                        n_pad    = r_pad - 6'd1;
                        pad_done = (n_pad == 6'd0);
                    end
                    PH_FIXED: begin
                        if (!r_shift[6]) begin
                            acc_new = r_acc | (64'(i_cmd.data_byte) << r_shift[5:0]);
                        end
                        n_acc   = acc_new;
                        n_shift = r_shift + 7'd8;
                        n_left  = r_left - 4'd1;
                        fin     = (n_left == 4'd0);
                        raw     = acc_new;
                        if (r_enc[3:0] == TY_S2 && acc_new[15]) begin
                            raw[63:16] = '1;
                        end
                        if (r_enc[3:0] == TY_S4 && acc_new[31]) begin
                            raw[63:32] = '1;
                        end
                    end
                    PH_ULEB, PH_SLEB: begin
                        if (!r_shift[6]) begin
                            acc_new = r_acc | (64'(i_cmd.data_byte[6:0]) << r_shift[5:0]);
                        end
                        sh_new  = r_shift + 7'd7;
                        n_acc   = acc_new;
                        n_shift = sh_new;
                        limit   = (taken1 >= 7'(MAX_LEB_BYTES));
                        fin     = limit || !i_cmd.data_byte[7];
                        ovl     = limit;
                        raw     = acc_new;
                        if (r_phase == PH_SLEB && i_cmd.data_byte[6] && !sh_new[6]) begin
                            raw = raw | ('1 << sh_new[5:0]);
                        end
                    end
                    default: begin
                    end
                endcase
                if (fin) begin
                    unique case (r_enc[6:4])
                        MOD_PCREL:   base = r_pc;
                        MOD_TEXTREL: base = i_cfg.text_base;
                        MOD_DATAREL: base = i_cfg.data_base;
                        MOD_FUNCREL: base = i_cfg.func_base;
                        default:     base = '0;
                    endcase
                    res_push       = 1'b1;
                    res.pointer    = raw + base;
                    res.byte_count = taken1;
                    res.written    = 1'b1;
                    res.overlong   = ovl;
                end
            end
        end
    end

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        if (go) begin
            if (i_cmd.is_start) begin
                n_phase = i_cmd.immediate ? PH_IDLE : i_cmd.init_phase;
            end else begin
                unique case (r_phase)
                    PH_IDLE:  n_phase = PH_IDLE;
                    PH_PAD:   n_phase = pad_done ? PH_FIXED : PH_PAD;
                    PH_FIXED,
                    PH_ULEB,
                    PH_SLEB:  n_phase = fin ? PH_IDLE : r_phase;
                    default:  n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_enc   <= '0;
            r_pc    <= '0;
            r_pad   <= '0;
            r_left  <= '0;
            r_taken <= '0;
            r_acc   <= '0;
            r_shift <= '0;
        end else begin
            r_phase <= n_phase;
            r_enc   <= n_enc;
            r_pc    <= n_pc;
            r_pad   <= n_pad;
            r_left  <= n_left;
            r_taken <= n_taken;
            r_acc   <= n_acc;
            r_shift <= n_shift;
        end
    end

    // result queue
    assign empty    = (r_rcount == 2'd0);
    assign res_pop  = pop && !empty;
    assign o_result = r_rq[r_rrd];

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_rwr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwr    <= 1'b0;
            r_rrd    <= 1'b0;
            r_rcount <= '0;
        end else begin
            r_rwr    <= r_rwr ^ res_push;
            r_rrd    <= r_rrd ^ res_pop;
            r_rcount <= r_rcount + 2'(res_push) - 2'(res_pop);
        end
    end

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcount <= 2'(RES_DEPTH))
        else $error("result queue overfilled");

    a_omit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && !res.written) |-> (res.pointer == '0 && res.byte_count == '0))
        else $error("omit result carries data");

    a_overlong_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res.overlong) |-> (res.byte_count == 7'(MAX_LEB_BYTES)))
        else $error("overlong flag on a short field");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && !i_cmd.is_start && fin) |=> (r_phase == PH_IDLE))
        else $error("sequencer busy after field end");

endmodule

@@ design/eh_pointer_field_decoder.sv @@
// an item is taken in the cycle push is high and full is low; its result,
// if any, reaches o_result through the command queue, then the result queue.
// throughput: one item per cycle, set by the back end sequencer taking one queued
// transaction per cycle while 2-entry result queue has room; 4-entry command queue.
// reset: synchronous active low; clears queues, sequencer and config (align_log2 = 3).
// top level: configuration registers, front end and back end; depends on ehpd_pkg
module eh_pointer_field_decoder import ehpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result
);

    t_cfg r_cfg;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{text_base: '0, data_base: '0, func_base: '0, align_log2: 3'd3};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEXT_BASE:  r_cfg.text_base  <= i_cfg_wdata;
                CFG_DATA_BASE:  r_cfg.data_base  <= i_cfg_wdata;
                CFG_FUNC_BASE:  r_cfg.func_base  <= i_cfg_wdata;
                CFG_ALIGN_LOG2: r_cfg.align_log2 <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    ehpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_align_log2 (r_cfg.align_log2),
        .push         (push),
        .full         (full),
        .i_item       (i_item),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_pop    (cmd_pop),
        .o_cmd        (cmd)
    );

    ehpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
